[rtl/seven_segment_text_scan_driver_top_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the seven-segment text scan driver
// Clocked, reset-qualified forms for same-cycle and next-cycle checks.
// ----------------------------------------------------------------------------
`ifndef SEVEN_SEGMENT_TEXT_SCAN_DRIVER_TOP_MACROS_SVH
`define SEVEN_SEGMENT_TEXT_SCAN_DRIVER_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SSD_ASSERT_NOW(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SSD_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/ssd_pkg.sv]
// ----------------------------------------------------------------------------
// Seven-segment text scan driver package
// Shared constants, command and result types, and the character glyph table.
// ----------------------------------------------------------------------------
package ssd_pkg;

	localparam int DIGITS = 4;
	localparam int IDX_W = (DIGITS > 1) ? $clog2(DIGITS) : 1;
	localparam int POS_W = 3;
	localparam int SLOT_W = 9;
	localparam int EN_W = 4;
	localparam int BLANK_W = 8;

	localparam logic [1:0] OP_BEGIN = 2'd0;
	localparam logic [1:0] OP_CHAR = 2'd1;
	localparam logic [1:0] OP_TICK = 2'd2;
	localparam logic [1:0] OP_UNUSED = 2'd3;

	localparam logic [7:0] CHAR_DOT = 8'h2E;
	localparam logic [7:0] SEG_DP = 8'h80;
	localparam logic [7:0] SEG_G = 8'h40;

	typedef enum logic [1:0] {
		CMD_BEGIN,
		CMD_CHAR,
		CMD_DOT,
		CMD_TICK
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t kind;
		logic [7:0] glyph;
	} cmd_t;

	typedef struct packed {
		logic [7:0] segments_n;
		logic [EN_W-1:0] digit_enables_n;
	} res_t;

	typedef struct packed {
		logic push;
	} res_ctl_t;

	function automatic logic [7:0] glyph_of(input logic [7:0] c);
		logic [7:0] g;
		case (c)
			8'h30: g = 8'h3F;
			8'h31: g = 8'h06;
			8'h32: g = 8'h5B;
			8'h33: g = 8'h4F;
			8'h34: g = 8'h66;
			8'h35: g = 8'h6D;
			8'h36: g = 8'h7D;
			8'h37: g = 8'h07;
			8'h38: g = 8'h7F;
			8'h39: g = 8'h6F;
			8'h2D: g = SEG_G;
			8'h41: g = 8'h77;
			8'h61: g = 8'h5F;
			8'h62: g = 8'h7C;
			8'h43: g = 8'h39;
			8'h63: g = 8'h58;
			8'h64: g = 8'h5E;
			8'h45: g = 8'h79;
			8'h65: g = 8'h7B;
			8'h46: g = 8'h71;
			8'h47: g = 8'h3D;
			8'h67: g = 8'h6F;
			8'h48: g = 8'h76;
			8'h68: g = 8'h74;
			8'h49: g = 8'h06;
			8'h69: g = 8'h04;
			8'h4A: g = 8'h1E;
			8'h4B: g = 8'h7A;
			8'h4C: g = 8'h38;
			8'h6C: g = 8'h06;
			8'h6E: g = 8'h54;
			8'h4F: g = 8'h3F;
			8'h6F: g = 8'h5C;
			8'h50: g = 8'h73;
			8'h52: g = 8'h31;
			8'h72: g = 8'h50;
			8'h53: g = 8'h6D;
			8'h74: g = 8'h78;
			8'h55: g = 8'h3E;
			8'h75: g = 8'h1C;
			8'h56: g = 8'h1C;
			8'h3F: g = 8'h53;
			default: g = 8'h00;
		endcase
		return g;
	endfunction

endpackage

[rtl/ssd_front.sv]
// ----------------------------------------------------------------------------
// Front end: item decode and command queue
// Classifies each accepted item, looks up its glyph and queues the command.
// ----------------------------------------------------------------------------
module ssd_front
	import ssd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [1:0] opcode,
	input  logic [7:0] char_code,
	output logic       cmd_valid,
	output cmd_t       cmd,
	input  logic       cmd_pop
);

	cmd_t mem_q [2];
	logic wr_ptr_q;
	logic rd_ptr_q;
	logic [1:0] count_q;
	logic enq;
	cmd_t dec;

	always_comb begin
		enq = 1'b0;
		dec.kind = CMD_TICK;
		dec.glyph = glyph_of(char_code);
		case (opcode)
			OP_BEGIN: begin
				enq = 1'b1;
				dec.kind = CMD_BEGIN;
			end
			OP_CHAR: begin
				enq = 1'b1;
				dec.kind = (char_code == CHAR_DOT) ? CMD_DOT : CMD_CHAR;
			end
			OP_TICK: begin
				enq = 1'b1;
				dec.kind = CMD_TICK;
			end
			default: enq = 1'b0;
		endcase
		enq = enq && push && !full;
	end

	assign full = (count_q == 2'd2);
	assign cmd_valid = (count_q != 2'd0);
	assign cmd = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (enq) begin
			mem_q[wr_ptr_q] <= dec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (enq) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (cmd_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			count_q <= count_q + {1'b0, enq} - {1'b0, cmd_pop};
		end
	end

endmodule

[rtl/ssd_back.sv]
// ----------------------------------------------------------------------------
// Back end: text buffer and scan execution
// Applies queued commands to the segment buffer and produces scan drives.
// ----------------------------------------------------------------------------
module ssd_back
	import ssd_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [BLANK_W-1:0] cfg_wdata,
	input  logic               cmd_valid,
	input  cmd_t               cmd,
	output logic               cmd_pop,
	input  logic               res_room,
	output res_ctl_t           res_ctl,
	output res_t               res
);

	logic [7:0] buf_q [DIGITS];
	logic [POS_W-1:0] wpos_q;
	logic past_end_q;
	logic [SLOT_W-1:0] slot_q;
	logic [BLANK_W-1:0] blank_slots_q;

	logic [IDX_W-1:0] wr_idx;
	logic [IDX_W-1:0] dot_idx;
	logic [SLOT_W-1:0] slot_inc;
	logic [SLOT_W-1:0] slot_bound;
	logic [SLOT_W-1:0] slot_next;

	assign cmd_pop = cmd_valid && ((cmd.kind != CMD_TICK) || res_room);
	assign res_ctl.push = cmd_pop && (cmd.kind == CMD_TICK);

	assign wr_idx = wpos_q[IDX_W-1:0];
	assign dot_idx = wr_idx + IDX_W'(1);
	assign slot_inc = slot_q + SLOT_W'(1);
	assign slot_bound = SLOT_W'(DIGITS) + {{(SLOT_W-BLANK_W){1'b0}}, blank_slots_q};
	assign slot_next = (slot_inc >= slot_bound) ? '0 : slot_inc;

	always_comb begin
		res.segments_n = 8'hFF;
		res.digit_enables_n = '1;
		if (slot_q < SLOT_W'(DIGITS)) begin
			res.segments_n = ~buf_q[slot_q[IDX_W-1:0]];
			if (slot_q < SLOT_W'(EN_W)) begin
				res.digit_enables_n = ~(EN_W'(1) << slot_q[$clog2(EN_W)-1:0]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blank_slots_q <= '0;
		end else if (cfg_we) begin
			blank_slots_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DIGITS; i++) begin
				buf_q[i] <= 8'h00;
			end
			wpos_q <= POS_W'(DIGITS - 1);
			past_end_q <= 1'b0;
			slot_q <= '0;
		end else if (cmd_pop) begin
			case (cmd.kind)
				CMD_BEGIN: begin
					for (int i = 0; i < DIGITS; i++) begin
						buf_q[i] <= 8'h00;
					end
					wpos_q <= POS_W'(DIGITS - 1);
					past_end_q <= 1'b0;
				end
				CMD_CHAR: begin
					if (!past_end_q) begin
						buf_q[wr_idx] <= cmd.glyph;
						if (wpos_q == '0) begin
							past_end_q <= 1'b1;
						end else begin
							wpos_q <= wpos_q - POS_W'(1);
						end
					end
				end
				CMD_DOT: begin
					// A dot before any character of the text has no digit to mark.
					if (past_end_q) begin
						buf_q[0] <= buf_q[0] | SEG_DP;
					end else if (wpos_q < POS_W'(DIGITS - 1)) begin
						buf_q[dot_idx] <= buf_q[dot_idx] | SEG_DP;
					end
				end
				CMD_TICK: begin
					slot_q <= slot_next;
				end
				default: begin
					slot_q <= slot_q;
				end
			endcase
		end
	end

endmodule

[rtl/ssd_result_q.sv]
// ----------------------------------------------------------------------------
// Result queue
// Two-entry queue holding scan drives until they are popped.
// ----------------------------------------------------------------------------
module ssd_result_q
	import ssd_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  res_ctl_t        res_ctl,
	input  res_t            res,
	output logic            res_room,
	input  logic            pop,
	output logic            empty,
	output logic [7:0]      segments_n,
	output logic [EN_W-1:0] digit_enables_n
);

	res_t mem_q [2];
	logic wr_ptr_q;
	logic rd_ptr_q;
	logic [1:0] count_q;
	logic deq;

	assign empty = (count_q == 2'd0);
	assign deq = pop && !empty;
	assign res_room = (count_q != 2'd2) || deq;
	assign segments_n = mem_q[rd_ptr_q].segments_n;
	assign digit_enables_n = mem_q[rd_ptr_q].digit_enables_n;

	always_ff @(posedge clk) begin
		if (res_ctl.push) begin
			mem_q[wr_ptr_q] <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (res_ctl.push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (deq) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			count_q <= count_q + {1'b0, res_ctl.push} - {1'b0, deq};
		end
	end

endmodule

[rtl/seven_segment_text_scan_driver_top.sv]
// ----------------------------------------------------------------------------
// Seven-segment text scan driver, top level
// One item per cycle while the command queue has room; a scan tick's drives
// pass the command and result queues, both two-entry, before they can be popped.
// Reset blanks the text, leaves the write position leftmost and zeroes the scan.
// ----------------------------------------------------------------------------
`include "seven_segment_text_scan_driver_top_macros.svh"

module seven_segment_text_scan_driver_top
	import ssd_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic [1:0]         opcode,
	input  logic [7:0]         char_code,
	input  logic               pop,
	output logic               empty,
	output logic [7:0]         segments_n,
	output logic [EN_W-1:0]    digit_enables_n,
	input  logic               cfg_we,
	input  logic [BLANK_W-1:0] cfg_wdata
);

	logic cmd_valid;
	cmd_t cmd;
	logic cmd_pop;
	logic res_room;
	res_ctl_t res_ctl;
	res_t res;

	ssd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.opcode    (opcode),
		.char_code (char_code),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop)
	);

	ssd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop),
		.res_room  (res_room),
		.res_ctl   (res_ctl),
		.res       (res)
	);

	ssd_result_q u_result_q (
		.clk             (clk),
		.arst_n          (arst_n),
		.res_ctl         (res_ctl),
		.res             (res),
		.res_room        (res_room),
		.pop             (pop),
		.empty           (empty),
		.segments_n      (segments_n),
		.digit_enables_n (digit_enables_n)
	);

	`SSD_ASSERT_NOW(a_push_has_room, clk, arst_n, res_ctl.push, res_room, "result pushed while full")
	`SSD_ASSERT_NOW(a_one_digit_lit, clk, arst_n, !empty, $countones(~digit_enables_n) <= 1, "more than one digit enabled")
	`SSD_ASSERT_NEXT(a_cmd_queued, clk, arst_n, push && !full && (opcode != OP_UNUSED), cmd_valid, "accepted item missing from command queue")

endmodule
